/* rtl/lrad_pkg.sv */
// ----------------------------------------------------------------------------
// lrad_pkg
// Shared constants for the low-rank adapter delta unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrad_pkg;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_ACT    = 2'd2;

    localparam logic [1:0] REG_IN_FEATURES  = 2'd0;
    localparam logic [1:0] REG_OUT_FEATURES = 2'd1;
    localparam logic [1:0] REG_RANK         = 2'd2;
    localparam logic [1:0] REG_SCALE        = 2'd3;

    localparam int ACC_W = 40;

endpackage

`default_nettype wire

/* rtl/low_rank_adapter_delta_unit.sv */
// ----------------------------------------------------------------------------
// low_rank_adapter_delta_unit
// A weight load does not raise busy; an activation holds busy while it walks
// the ranks (all accumulators at row position 0, which clears them). The row's
// last activation then streams out_features results, one per output row,
// then busy stays high while the accumulators clear.
// Throughput is set by the multiply-accumulate steps and one
// accumulator memory port per step. The receiver cannot stall.
// Reset clears control state and the configuration registers, then holds busy
// while the accumulators clear; weight memories are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module low_rank_adapter_delta_unit #(
    parameter int MAX_IN   = 256,
    parameter int MAX_OUT  = 64,
    parameter int MAX_RANK = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [5:0]  row_index,
    input  wire logic [7:0]  col_index,
    input  wire logic signed [15:0] value,
    output logic             done,
    output logic signed [15:0] delta_value,
    output logic [5:0]       out_index,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import lrad_pkg::*;

    localparam int IN_W  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int RK_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int A_D   = MAX_RANK * MAX_IN;
    localparam int B_D   = MAX_OUT * MAX_RANK;
    localparam int A_AW  = $clog2(A_D > 1 ? A_D : 2);
    localparam int B_AW  = $clog2(B_D > 1 ? B_D : 2);
    localparam int HI_IN = (MAX_IN < 256) ? MAX_IN : 256;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_ROW  = 3'd2;
    localparam logic [2:0] S_SCL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;

    // ---------------- configuration ----------------
    logic [8:0]  in_f_reg;
    logic [6:0]  out_f_reg;
    logic [4:0]  rank_reg;
    logic [15:0] scale_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_f_reg  <= 9'd256;
            out_f_reg <= 7'd64;
            rank_reg  <= 5'd8;
            scale_reg <= 16'd256;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IN_FEATURES:  in_f_reg  <= pwdata[8:0];
                REG_OUT_FEATURES: out_f_reg <= pwdata[6:0];
                REG_RANK:         rank_reg  <= pwdata[4:0];
                REG_SCALE:        scale_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IN_FEATURES:  prdata = {23'd0, in_f_reg};
            REG_OUT_FEATURES: prdata = {25'd0, out_f_reg};
            REG_RANK:         prdata = {27'd0, rank_reg};
            REG_SCALE:        prdata = {16'd0, scale_reg};
            default:          prdata = 32'd0;
        endcase
    end

    logic [12:0] n_in;
    logic [6:0]  n_out;
    logic [6:0]  n_rank;

    always_comb
    begin
        if (in_f_reg == 9'd0)                 n_in = 13'd1;
        else if ({4'd0, in_f_reg} > 13'(HI_IN)) n_in = 13'(HI_IN);
        else                                  n_in = {4'd0, in_f_reg};
        if (out_f_reg == 7'd0)                n_out = 7'd1;
        else if (out_f_reg > 7'(MAX_OUT))     n_out = 7'(MAX_OUT);
        else                                  n_out = out_f_reg;
        if (rank_reg == 5'd0)                 n_rank = 7'd1;
        else if ({2'd0, rank_reg} > 7'(MAX_RANK)) n_rank = 7'(MAX_RANK);
        else                                  n_rank = {2'd0, rank_reg};
    end

    // ---------------- memories ----------------
    logic            a_we, b_we, c_we;
    logic [A_AW-1:0] a_addr;
    logic [B_AW-1:0] b_addr;
    logic [RK_W-1:0] c_addr;
    logic [15:0]     a_rd, b_rd;
    logic [ACC_W-1:0] c_wd, c_rd;

    lrad_ram #(.WIDTH(16), .DEPTH(A_D)) u_amem (
        .clk(clk), .we(a_we), .addr(a_addr), .wdata(value), .rdata(a_rd));
    lrad_ram #(.WIDTH(16), .DEPTH(B_D)) u_bmem (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(value), .rdata(b_rd));
    lrad_ram #(.WIDTH(ACC_W), .DEPTH(MAX_RANK)) u_cmem (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

    // ---------------- control ----------------
    logic [2:0]       state_reg, state_next;
    logic [6:0]       k_reg, k_next;        // issue index
    logic [6:0]       kw_reg, kw_next;      // write-back/consume index
    logic             v1_reg, v1_next;      // read data valid this cycle
    logic [6:0]       j_reg, j_next;
    logic [IN_W:0]    col_reg;
    logic signed [15:0] x_reg;
    logic             zero_reg;             // row start: treat accumulators as zero
    logic             end_reg;
    logic signed [47:0] y_reg, y_next;
    logic signed [31:0] prod_reg;
    logic             pv_reg;
    logic signed [51:0] sy_reg;
    logic             done_next;
    logic [6:0]       mac_lim;

    // row start walks every accumulator so unused ranks are cleared too
    assign mac_lim = zero_reg ? 7'(MAX_RANK) : n_rank;

    logic in_ok_a, in_ok_b;
    assign in_ok_a = ({2'd0, row_index} < 8'(MAX_RANK)) && ({5'd0, col_index} < 13'(MAX_IN));
    assign in_ok_b = ({1'd0, row_index} < 7'(MAX_OUT)) && ({5'd0, col_index} < 13'(MAX_RANK));

    assign busy = (state_reg != S_IDLE);

    // u from accumulator read data
    logic signed [ACC_W-1:0] acc_s;
    logic signed [ACC_W:0]   acc_p;
    logic signed [ACC_W-12:0] acc_r;
    logic signed [15:0] u_val;
    assign acc_s = c_rd;
    assign acc_p = (ACC_W+1)'(acc_s) + (ACC_W+1)'(2048);
    assign acc_r = acc_p[ACC_W:12];
    always_comb
    begin
        if (acc_r > 29'sd32767)       u_val = 16'sh7fff;
        else if (acc_r < -29'sd32768) u_val = 16'sh8000;
        else                          u_val = acc_r[15:0];
    end

    logic signed [51:0] yr;
    logic signed [31:0] yq;
    assign yr = sy_reg + 52'sd524288;
    assign yq = yr[51:20];

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        kw_next    = kw_reg;
        v1_next    = 1'b0;
        j_next     = j_reg;
        y_next     = y_reg;
        done_next  = 1'b0;
        a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
        a_addr = A_AW'(({26'd0, row_index} * MAX_IN) + {24'd0, col_index});
        b_addr = B_AW'(({26'd0, row_index} * MAX_RANK) + {24'd0, col_index});
        c_addr = RK_W'(k_reg);
        c_wd   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD_A) a_we = in_ok_a;
                    else if (opcode == OP_LOAD_B) b_we = in_ok_b;
                    else if (opcode == OP_ACT && {5'd0, col_index} < n_in)
                    begin
                        state_next = S_MAC;
                        k_next = 7'd0;
                        kw_next = 7'd0;
                    end
                end
            end
            S_MAC:
            begin
                // issue reads of A[k][col] and acc[k]; write back once the read data arrives
                a_addr = A_AW'((32'(k_reg) * MAX_IN) + 32'(col_reg));
                if (v1_reg)
                begin
                    c_we   = 1'b1;
                    c_addr = RK_W'(kw_reg);
                    c_wd   = (zero_reg ? '0 : c_rd)
                             + ((kw_reg < n_rank) ? ACC_W'($signed(a_rd) * x_reg) : '0);
                    kw_next = kw_reg + 7'd1;
                end
                else
                begin
                    c_addr = RK_W'(k_reg);
                end
                if (!v1_reg && k_reg < mac_lim)
                begin
                    v1_next = 1'b1;
                    k_next  = k_reg + 7'd1;
                end
                else if (!v1_reg)
                begin
                    if (end_reg)
                    begin
                        state_next = S_ROW;
                        j_next = 7'd0;
                        k_next = 7'd0;
                        y_next = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ROW:
            begin
                // read acc[k] and B[j][k]; accumulate B*u when both arrive
                b_addr = B_AW'((32'(j_reg) * MAX_RANK) + 32'(k_reg));
                c_addr = RK_W'(k_reg);
                if (k_reg < n_rank)
                begin
                    v1_next = 1'b1;
                    k_next = k_reg + 7'd1;
                end
                if (pv_reg)
                begin
                    y_next = y_reg + 48'(prod_reg);
                end
                if (k_reg >= n_rank && !v1_reg && !pv_reg)
                begin
                    state_next = S_SCL;
                end
            end
            S_SCL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                y_next = '0;
                k_next = 7'd0;
                j_next = j_reg + 7'd1;
                if (j_reg + 7'd1 >= n_out)
                begin
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_CLR:
            begin
                c_we = 1'b1;
                c_addr = RK_W'(k_reg);
                c_wd = '0;
                k_next = k_reg + 7'd1;
                if (k_reg + 7'd1 >= 7'(MAX_RANK))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            k_reg     <= 7'd0;
            kw_reg    <= 7'd0;
            v1_reg    <= 1'b0;
            j_reg     <= 7'd0;
            pv_reg    <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            kw_reg    <= kw_next;
            v1_reg    <= v1_next;
            j_reg     <= j_next;
            pv_reg    <= (state_reg == S_ROW) && v1_reg;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        prod_reg <= $signed(b_rd) * u_val;
        if (state_reg == S_ROW && state_next == S_SCL)
        begin
            sy_reg <= 52'(y_next) * $signed(scale_reg);
        end
        if (state_reg == S_IDLE && start)
        begin
            col_reg  <= (IN_W+1)'(col_index);
            x_reg    <= value;
            zero_reg <= (col_index == 8'd0);
            end_reg  <= ({5'd0, col_index} == n_in - 13'd1);
        end
        if (done_next)
        begin
            if (yq > 32'sd32767)       delta_value <= 16'sh7fff;
            else if (yq < -32'sd32768) delta_value <= 16'sh8000;
            else                       delta_value <= yq[15:0];
            out_index <= 6'(j_reg);
            last      <= (j_reg + 7'd1 >= n_out);
        end
    end

endmodule

`default_nettype wire

/* rtl/lrad_ram.sv */
// ----------------------------------------------------------------------------
// lrad_ram
// Single-port RAM, one access per cycle, registered read (old data on write).
// ----------------------------------------------------------------------------
`default_nettype none

module lrad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire
